/* sv/bwa_pkg.sv */
package bwa_pkg;

   localparam logic [31:0] PHASE_STEP_RESET = 32'd65536;

   // pi/2 in Q2.30
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // 0.42 in Q31 (27525 * 2^15) and 0.08 in Q16
   localparam logic signed [32:0] W_A0_Q31 = 33'sd901939200;
   localparam logic signed [32:0] W_A2_Q16 = 33'sd5243;

   localparam logic [15:0] COS_ONE_Q15 = 16'd32768;

   // quarter-wave cosine entry k of a 2^b step quarter, Q15, 0..32768
   function automatic logic [15:0] cos_entry(input int unsigned k, input int unsigned b);
      logic [63:0] full;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] mag;
      logic [63:0] rounded;
      logic signed [63:0] sum;
      full = 64'd1 << b;
      if (k == 0) begin
         return COS_ONE_Q15;
      end
      if (64'(k) >= full) begin
         return 16'd0;
      end
      x = (PI_HALF_Q30 * 64'(k) + (64'd1 << (b - 1))) >> b;
      x2 = (x * x) >> 30;
      mag = 64'd1 << 30;
      sum = signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd2;
      sum = sum - signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd12;
      sum = sum + signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd30;
      sum = sum - signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd56;
      sum = sum + signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd90;
      sum = sum - signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd132;
      sum = sum + signed'(mag);
      mag = ((mag * x2) >> 30) / 64'd182;
      sum = sum - signed'(mag);
      if (sum < 0) begin
         return 16'd0;
      end
      rounded = (unsigned'(sum) + 64'd16384) >> 15;
      if (rounded > 64'd32768) begin
         rounded = 64'd32768;
      end
      return 16'(rounded);
   endfunction

endpackage

/* sv/blackman_window_apply.sv */
// channel   | ports                                          | direction
// ----------+------------------------------------------------+-----------
// request   | req_valid req_stall req_sample_in req_position | in
// response  | rsp_valid rsp_stall rsp_sample_out             | out
// csr       | csr_write_enable csr_write_data                | in
//
// Six register stages: phase multiply, table address, table read, weight,
// sample multiply, round and saturate. One item per cycle while the response is not stalled.
// Synchronous reset clears the valid bits and sets phase_step to 65536.
// A stalled response freezes every stage together; the request side sees
// req_stall while the output register holds an item that is not taken.
module blackman_window_apply #(
   parameter int POSITION_BITS  = 16,
   parameter int COS_TABLE_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_in,
   input  logic        [15:0] req_position,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_write_enable,
   input  logic        [31:0] csr_write_data
);

   import bwa_pkg::*;

   localparam int B          = COS_TABLE_BITS;
   localparam int IDX_SHIFT  = 30 - B;
   localparam int TABLE_LAST = 1 << B;
   localparam int STAGES     = 6;
   localparam logic [15:0] POS_MASK =
      (POSITION_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << POSITION_BITS) - 32'd1);
   localparam logic [32:0] IDX_ROUND = 33'd1 << (IDX_SHIFT - 1);
   localparam logic [B:0]  TABLE_FULL = (B + 1)'(TABLE_LAST);

   logic [15:0] cos_rom [0:TABLE_LAST];

   for (genvar k = 0; k <= TABLE_LAST; k++) begin : g_rom
      assign cos_rom[k] = cos_entry(k, B);
   end

   logic [31:0]        phase_step_ff;
   logic [STAGES-1:0]  vld_ff;
   logic               advance;

   logic signed [15:0] sample_ff [1:4];

   logic [31:0]        phase_ff;
   logic [31:0]        phase_in;

   logic [B:0]         addr1_ff, addr2_ff;
   logic [B:0]         addr1_in, addr2_in;
   logic               neg1_ff, neg2_ff, neg1_s3_ff, neg2_s3_ff;
   logic               neg1_in, neg2_in;
   logic [15:0]        mag1_ff, mag2_ff;

   logic signed [15:0] weight_ff;
   logic signed [15:0] weight_in;
   logic signed [31:0] prod_ff;
   logic signed [15:0] out_ff;
   logic signed [15:0] out_in;

   logic [31:0]        phase2;
   logic [32:0]        idx1_sum, idx2_sum;
   logic [B+1:0]       idx1, idx2;
   logic signed [16:0] c1, c2;
   logic signed [32:0] w31;
   logic signed [32:0] w_rnd;
   logic signed [32:0] y_rnd;

   assign advance   = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_sample_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RESET;
         vld_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            phase_step_ff <= csr_write_data;
         end
         if (advance) begin
            vld_ff <= {vld_ff[STAGES-2:0], req_valid};
         end
      end
   end

   // phase = position * step mod 2^32
   assign phase_in = 32'({16'd0, req_position & POS_MASK} * phase_step_ff);

   // table addresses for phase and twice the phase
   always_comb begin
      phase2   = {phase_ff[30:0], 1'b0};
      idx1_sum = {1'b0, phase_ff} + IDX_ROUND;
      idx2_sum = {1'b0, phase2} + IDX_ROUND;
      idx1     = idx1_sum[31:IDX_SHIFT];
      idx2     = idx2_sum[31:IDX_SHIFT];
      addr1_in = idx1[B] ? TABLE_FULL - {1'b0, idx1[B-1:0]} : {1'b0, idx1[B-1:0]};
      addr2_in = idx2[B] ? TABLE_FULL - {1'b0, idx2[B-1:0]} : {1'b0, idx2[B-1:0]};
      neg1_in  = idx1[B+1] ^ idx1[B];
      neg2_in  = idx2[B+1] ^ idx2[B];
   end

   // weight = 0.42 - 0.5 c1 + 0.08 c2, rounded to Q15
   always_comb begin
      c1    = neg1_s3_ff ? -$signed({1'b0, mag1_ff}) : $signed({1'b0, mag1_ff});
      c2    = neg2_s3_ff ? -$signed({1'b0, mag2_ff}) : $signed({1'b0, mag2_ff});
      w31   = W_A0_Q31 - (33'(c1) <<< 15) + W_A2_Q16 * 33'(c2);
      w_rnd = (w31 + 33'sd32768) >>> 16;
      if (w_rnd > 33'sd32767) begin
         weight_in = 16'sh7FFF;
      end else if (w_rnd < -33'sd32768) begin
         weight_in = -16'sh8000;
      end else begin
         weight_in = w_rnd[15:0];
      end
   end

   always_comb begin
      y_rnd = (33'(prod_ff) + 33'sd16384) >>> 15;
      if (y_rnd > 33'sd32767) begin
         out_in = 16'sh7FFF;
      end else if (y_rnd < -33'sd32768) begin
         out_in = -16'sh8000;
      end else begin
         out_in = y_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phase_ff     <= phase_in;
         sample_ff[1] <= req_sample_in;

         addr1_ff     <= addr1_in;
         addr2_ff     <= addr2_in;
         neg1_ff      <= neg1_in;
         neg2_ff      <= neg2_in;
         sample_ff[2] <= sample_ff[1];

         mag1_ff      <= cos_rom[addr1_ff];
         mag2_ff      <= cos_rom[addr2_ff];
         neg1_s3_ff   <= neg1_ff;
         neg2_s3_ff   <= neg2_ff;
         sample_ff[3] <= sample_ff[2];

         weight_ff    <= weight_in;
         sample_ff[4] <= sample_ff[3];

         prod_ff      <= sample_ff[4] * weight_ff;

         out_ff       <= out_in;
      end
   end

endmodule

/* tb/blackman_window_checker.sv */
module blackman_window_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_sample_in,
   input  logic        [15:0] req_position,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_sample_out,
   input  logic               csr_write_enable,
   input  logic        [31:0] csr_write_data,
   output int                 error_count,
   output int                 outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int               QUARTER_BITS = 10;
   localparam int               QUARTER_SIZE = 1 << QUARTER_BITS;
   localparam int               PHASE_SHIFT  = 32 - (QUARTER_BITS + 2);
   localparam longint unsigned  HALF_PI_Q30  = 64'd1686629713;
   localparam longint           BLACKMAN_A0  = 27525;
   localparam longint           BLACKMAN_A2  = 5243;
   localparam logic [31:0]      STEP_AT_RESET = 32'd65536;
   localparam int               SAMPLE_MAX   = 32767;
   localparam int               SAMPLE_MIN   = -32768;

   int                 quarter_cos [0:QUARTER_SIZE];
   logic        [31:0] phase_step;
   logic signed [15:0] expected_out [$];
   logic signed [15:0] oldest;

   // quarter-wave cosine in Q15 from a Taylor series in Q30
   initial begin : build_quarter_wave
      longint unsigned x;
      longint unsigned x2;
      longint unsigned mag;
      longint          sum;
      int              k;
      int              n;
      quarter_cos[0] = 32768;
      quarter_cos[QUARTER_SIZE] = 0;
      for (k = 1; k < QUARTER_SIZE; k++) begin
         x   = (HALF_PI_Q30 * longint'(k) + (64'd1 << (QUARTER_BITS - 1))) >> QUARTER_BITS;
         x2  = (x * x) >> 30;
         mag = 64'd1 << 30;
         sum = longint'(mag);
         for (n = 1; n <= 7; n++) begin
            mag = ((mag * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               sum = sum - longint'(mag);
            end else begin
               sum = sum + longint'(mag);
            end
         end
         if (sum < 0) begin
            quarter_cos[k] = 0;
         end else begin
            sum = (sum + 16384) >>> 15;
            quarter_cos[k] = (sum > 32768) ? 32768 : int'(sum);
         end
      end
   end

   function automatic longint cosine_q15(input logic [31:0] phase);
      longint unsigned idx;
      int              quadrant;
      int              offset;
      idx = (longint'(phase) + (64'd1 << (PHASE_SHIFT - 1))) >> PHASE_SHIFT;
      idx = idx & ((64'd1 << (QUARTER_BITS + 2)) - 1);
      quadrant = int'(idx >> QUARTER_BITS);
      offset   = int'(idx) & (QUARTER_SIZE - 1);
      case (quadrant)
         0: return  quarter_cos[offset];
         1: return -quarter_cos[QUARTER_SIZE - offset];
         2: return -quarter_cos[offset];
         default: return quarter_cos[QUARTER_SIZE - offset];
      endcase
   endfunction

   function automatic logic signed [15:0] windowed_sample(input logic signed [15:0] sample,
                                                          input logic        [15:0] position,
                                                          input logic        [31:0] step);
      logic [31:0] phase;
      logic [31:0] phase2;
      longint      w31;
      longint      weight;
      longint      y;
      phase  = position * step;
      phase2 = phase << 1;
      w31 = BLACKMAN_A0 * 32768 - cosine_q15(phase) * 32768 + BLACKMAN_A2 * cosine_q15(phase2);
      weight = (w31 + 32768) >>> 16;
      if (weight > SAMPLE_MAX) weight = SAMPLE_MAX;
      if (weight < SAMPLE_MIN) weight = SAMPLE_MIN;
      y = (longint'(sample) * weight + 16384) >>> 15;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      return 16'(y);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase_step = STEP_AT_RESET;
         expected_out.delete();
         error_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_out.push_back(windowed_sample(req_sample_in, req_position, phase_step));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $display("%0t: sample_out expected none, got %0d", $time, rsp_sample_out);
               error_count++;
            end else begin
               oldest = expected_out.pop_front();
               if (rsp_sample_out !== oldest) begin
                  $display("%0t: sample_out expected %0d, got %0d",
                           $time, oldest, rsp_sample_out);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            phase_step = csr_write_data;
         end
      end
      outstanding = expected_out.size();
   end

endmodule

/* tb/tb_blackman_window_apply.sv */
module tb_blackman_window_apply;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int ITEMS_PER_PHASE = 113;
   localparam int PHASE_COUNT     = 9;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample_in = '0;
   logic        [15:0] req_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_sample_out;
   logic               csr_write_enable = 1'b0;
   logic        [31:0] csr_write_data = '0;
   int                 error_count;
   int                 outstanding;
   int                 cycle_count = 0;

   logic [31:0] step_plan [8] = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd67108864,
                                  32'd4194304, 32'd4294967, 32'd1, 32'd613566757};
   logic [15:0] edge_positions [8] = '{16'h0000, 16'h0001, 16'h4000, 16'h8000,
                                       16'hC000, 16'hFFFF, 16'h7FFF, 16'h2AAA};

   blackman_window_apply i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   blackman_window_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [15:0] sample, input logic [15:0] position);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      req_position  <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_phase_step(input logic [31:0] step);
      drain();
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= step;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random(input int count);
      int                 burst_left;
      int                 gap;
      logic signed [15:0] sample;
      logic        [15:0] position;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 39) == 0) begin
               drain();
            end else if ($urandom_range(0, 3) != 0) begin
               gap = $urandom_range(1, 6);
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
         case ($urandom_range(0, 7))
            0: sample = 16'sh7FFF;
            1: sample = 16'sh8000;
            2: sample = 16'($signed($urandom_range(0, 32)) - 16);
            default: sample = 16'($urandom());
         endcase
         case ($urandom_range(0, 5))
            0: position = 16'($urandom_range(0, 15));
            1: position = 16'($urandom_range(32760, 32776));
            2: position = 16'($urandom_range(0, 1023));
            default: position = 16'($urandom());
         endcase
         send_sample(sample, position);
      end
   endtask

   initial begin : rsp_stall_pattern
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 200);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (edge_positions[i]) begin
         send_sample(16'sh7FFF, edge_positions[i]);
         send_sample(16'sh8000, edge_positions[i]);
      end
      send_sample(16'sh0000, 16'h8000);
      send_sample(16'shFFFF, 16'h8000);
      send_sample(16'sh5555, 16'h5555);
      send_sample(16'shAAAA, 16'hAAAA);
      send_random(ITEMS_PER_PHASE);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_phase_step((p < $size(step_plan)) ? step_plan[p] : $urandom());
         send_random(ITEMS_PER_PHASE);
      end

      drain();
      repeat (12) @(negedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
sv/bwa_pkg.sv
sv/blackman_window_apply.sv
tb/blackman_window_checker.sv
tb/tb_blackman_window_apply.sv
